// ===== src/ndd_pkg.sv =====
// ----------------------------------------------------------------------------
// ndd_pkg: shared types and constants for number_to_display_digits
// Mode codes, digit limits, ASCII codes, cell control word and the
// digit-to-character mapping.
// ----------------------------------------------------------------------------
package ndd_pkg;

  // Mode codes
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_BIN  = 2'd3;

  // Digit row
  localparam int NUM_CELLS = 16;
  localparam int DIGIT_W   = 4;

  // Per-mode digit limits
  localparam logic [4:0] DEC_MAX_DIGITS = 5'd10;
  localparam logic [4:0] HEX_MAX_DIGITS = 5'd8;
  localparam logic [4:0] BIN_MAX_DIGITS = 5'd16;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_UPPER = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Control word broadcast to every cell
  typedef struct packed {
    logic load;    // take the parallel digit
    logic dabble;  // add-3 adjust, then shift one bit in from below
    logic shift;   // move the whole digit up one cell
  } cell_ctrl_t;

  // One digit (0..15) to its ASCII character
  function automatic logic [6:0] char_of(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      char_of = CHAR_ZERO + 7'(d);
    end else begin
      char_of = CHAR_UPPER + 7'(d - 4'd10);
    end
  endfunction

endpackage

// ===== src/ndd_num_if.sv =====
// ----------------------------------------------------------------------------
// ndd_num_if: number input channel
// Carries one number with its mode, digit count and text position.
// ----------------------------------------------------------------------------
interface ndd_num_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [31:0] value;
  logic [4:0] digit_count;
  logic [2:0] text_line;
  logic [4:0] start_column;

  modport source (output valid, op, value, digit_count, text_line, start_column,
                  input ready);
  modport sink   (input valid, op, value, digit_count, text_line, start_column,
                  output ready);
endinterface

// ===== src/ndd_char_if.sv =====
// ----------------------------------------------------------------------------
// ndd_char_if: character output channel
// Carries one display character with its line, column and last flag.
// ----------------------------------------------------------------------------
interface ndd_char_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_line;
  logic [4:0] out_column;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, out_line, out_column, char_code, last,
                  input ready);
  modport sink   (input valid, out_line, out_column, char_code, last,
                  output ready);
endinterface

// ===== src/ndd_cell.sv =====
// ----------------------------------------------------------------------------
// ndd_cell: one digit cell of the conversion row
// Holds one 4-bit digit. Loads in parallel, does one double-dabble step
// (adjust, then shift a bit in from the lower neighbor), or moves its digit
// up to the next cell during character output.
// ----------------------------------------------------------------------------
module ndd_cell
  import ndd_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [DIGIT_W-1:0] load_digit,
  input  logic               carry_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] adj;

  // add 3 when the digit would pass 9 after doubling
  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry_out = adj[DIGIT_W-1];
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digit_r <= load_digit;
    end else if (ctrl.dabble) begin
      digit_r <= {adj[DIGIT_W-2:0], carry_in};
    end else if (ctrl.shift) begin
      digit_r <= digit_in;
    end
  end

endmodule

// ===== src/number_to_display_digits.sv =====
// ----------------------------------------------------------------------------
// number_to_display_digits: number to ASCII display characters
// Takes one number word on num_in and sends its characters on char_out,
// most significant digit first, each with line, column and a last flag.
//
// Channels: valid/ready on both sides; a word moves when both are high.
// num_in is taken only while the block is idle. Modes: unsigned decimal,
// signed decimal (sign character first), uppercase hex, binary.
// Decimal words pass through NUMBER_BITS double-dabble steps in a row of
// sixteen 4-bit digit cells, one bit per cycle; hex and binary load the
// cells in parallel at accept. Characters then leave one per cycle while
// char_out is free, read from the highest used cell as the cells shift up.
// Hex and binary words go straight to character output; decimal words
// first pass through the conversion state.
// A zero digit count gives only the sign in signed mode, nothing otherwise.
// Stalls on char_out hold the output register and pause the row.
// Reset (rst, synchronous) returns to idle and drops any pending character.
// ----------------------------------------------------------------------------
module number_to_display_digits
  import ndd_pkg::*;
#(
  parameter int NUMBER_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  ndd_num_if.sink    num_in,
  ndd_char_if.source char_out
);

  localparam int CNT_W = $clog2(NUMBER_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state;
  logic [CNT_W-1:0]       conv_count;
  logic [NUMBER_BITS-1:0] sreg;
  logic [4:0]             remaining;
  logic [3:0]             top_idx;
  logic [2:0]             line;
  logic [4:0]             col;
  logic                   sign_pending;
  logic                   neg;

  // Output register
  logic       out_valid;
  logic [2:0] out_line_r;
  logic [4:0] out_column_r;
  logic [6:0] char_code_r;
  logic       last_r;

  // Input decode
  logic                   accept;
  logic [NUMBER_BITS-1:0] val_m;
  logic                   in_neg;
  logic [NUMBER_BITS-1:0] mag;
  logic [31:0]            mag32;
  logic [4:0]             max_digits;
  logic [4:0]             len;

  assign accept = num_in.valid && num_in.ready;
  assign val_m  = num_in.value[NUMBER_BITS-1:0];
  assign in_neg = (num_in.op == OP_SDEC) && val_m[NUMBER_BITS-1];
  assign mag    = in_neg ? (~val_m + 1'b1) : val_m;
  assign mag32  = 32'(mag);

  always_comb begin
    case (num_in.op)
      OP_HEX:  max_digits = HEX_MAX_DIGITS;
      OP_BIN:  max_digits = BIN_MAX_DIGITS;
      default: max_digits = DEC_MAX_DIGITS;
    endcase
    len = (num_in.digit_count > max_digits) ? max_digits : num_in.digit_count;
  end

  // Cell row control
  logic                   out_free;
  logic                   emit_digit;
  logic                   emit_sign;
  cell_ctrl_t             ctrl;
  logic [DIGIT_W-1:0]     load_digit [NUM_CELLS];
  logic [DIGIT_W-1:0]     digit      [NUM_CELLS];
  logic [NUM_CELLS-1:0]   carry;

  assign out_free   = !out_valid || char_out.ready;
  assign emit_sign  = (state == S_EMIT) && out_free && sign_pending;
  assign emit_digit = (state == S_EMIT) && out_free && !sign_pending;

  assign ctrl.load   = accept;
  assign ctrl.dabble = (state == S_CONV);
  assign ctrl.shift  = emit_digit;

  // Parallel load digits: zero for decimal, nibbles for hex, bits for binary
  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      load_digit[i] = '0;
      if (num_in.op == OP_HEX && i < 8) begin
        load_digit[i] = mag32[4*i +: 4];
      end else if (num_in.op == OP_BIN) begin
        load_digit[i] = {3'b000, mag32[i]};
      end
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ndd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_digit (load_digit[k]),
      .carry_in   ((k == 0) ? sreg[NUMBER_BITS-1] : carry[(k == 0) ? 0 : k-1]),
      .digit_in   ((k == 0) ? {DIGIT_W{1'b0}} : digit[(k == 0) ? 0 : k-1]),
      .digit      (digit[k]),
      .carry_out  (carry[k])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sign_pending <= 1'b0;
      conv_count   <= '0;
      remaining    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sign_pending <= (num_in.op == OP_SDEC);
            remaining    <= len;
            conv_count   <= CNT_W'(NUMBER_BITS);
            if (num_in.op == OP_UDEC || num_in.op == OP_SDEC) begin
              state <= S_CONV;
            end else if (len != 5'd0) begin
              state <= S_EMIT;
            end
          end
        end
        S_CONV: begin
          conv_count <= conv_count - 1'b1;
          if (conv_count == CNT_W'(1)) begin
            state <= (sign_pending || remaining != 5'd0) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_sign) begin
            sign_pending <= 1'b0;
            if (remaining == 5'd0) begin
              state <= S_IDLE;
            end
          end else if (emit_digit) begin
            remaining <= remaining - 1'b1;
            if (remaining == 5'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-word payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sreg    <= mag;
      line    <= num_in.text_line;
      col     <= num_in.start_column;
      neg     <= in_neg;
      top_idx <= 4'(len - 5'd1);
    end else begin
      if (state == S_CONV) begin
        sreg <= {sreg[NUMBER_BITS-2:0], 1'b0};
      end
      if (emit_sign || emit_digit) begin
        col <= col + 5'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      out_valid <= 1'b1;
    end else if (char_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      out_line_r   <= line;
      out_column_r <= col;
      char_code_r  <= neg ? CHAR_MINUS : CHAR_PLUS;
      last_r       <= (remaining == 5'd0);
    end else if (emit_digit) begin
      out_line_r   <= line;
      out_column_r <= col;
      char_code_r  <= char_of(digit[top_idx]);
      last_r       <= (remaining == 5'd1);
    end
  end

  assign num_in.ready        = (state == S_IDLE);
  assign char_out.valid      = out_valid;
  assign char_out.out_line   = out_line_r;
  assign char_out.out_column = out_column_r;
  assign char_out.char_code  = char_code_r;
  assign char_out.last       = last_r;

`ifndef SYNTHESIS
  // sign is always sent before the block goes idle again
  a_idle_no_sign: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sign_pending)
    else $error("sign pending while idle");

  // digit output never runs with nothing left to send
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sign_pending) |-> remaining != 5'd0)
    else $error("digit output with zero count");

  // conversion counter never underflows
  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV |-> conv_count != '0)
    else $error("conversion counter at zero");

  // character count stays within the row
  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    remaining <= 5'(NUM_CELLS))
    else $error("character count beyond cell row");
`endif

endmodule

// ===== tb/number_to_display_digits_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_display_digits_test: self-checking bench for number_to_display_digits
// Sends number words with directed corner cases, then random traffic under
// four handshake phases. A built-in predictor turns each accepted word into
// the expected display characters, and a checker compares every character
// word from the block against them in order.
// ----------------------------------------------------------------------------
module number_to_display_digits_test
  import ndd_pkg::*;
();

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 60;     // longer than one word's busy time
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [4:0]  digit_count;
    logic [2:0]  text_line;
    logic [4:0]  start_column;
  } number_word_t;

  typedef struct packed {
    logic [2:0] line;
    logic [4:0] column;
    logic [6:0] code;
    logic       last;
  } glyph_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;

  ndd_num_if  num_bus ();
  ndd_char_if glyph_bus ();

  number_to_display_digits #(.NUMBER_BITS(32)) DUT (
    .clk      (clk),
    .rst      (rst),
    .num_in   (num_bus),
    .char_out (glyph_bus)
  );

  // expected display characters, oldest first
  glyph_t expected_chars[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int numbers_sent = 0;
  int chars_checked = 0;

  // clock and cycle counter
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d characters still expected",
             cycle_count, expected_chars.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // predictor: digits of the number in the chosen radix, MSD first
  function automatic void predict_display_chars(input number_word_t w);
    logic [31:0] mag;
    logic [63:0] scale;
    logic [3:0]  dig;
    logic [4:0]  col;
    int          len;
    int          cap;
    int          pos;
    glyph_t      g;
    mag = w.value;
    col = w.start_column;
    len = w.digit_count;
    case (w.op)
      OP_HEX:  cap = HEX_MAX_DIGITS;
      OP_BIN:  cap = BIN_MAX_DIGITS;
      default: cap = DEC_MAX_DIGITS;
    endcase
    if (len > cap) len = cap;
    // signed decimal: sign character, then the magnitude
    if (w.op == OP_SDEC) begin
      g.line = w.text_line;
      g.column = col;
      g.code = mag[31] ? CHAR_MINUS : CHAR_PLUS;
      g.last = (len == 0);
      expected_chars.push_back(g);
      if (mag[31]) mag = 32'd0 - mag;
      col = col + 5'd1;
    end
    for (int i = 0; i < len; i++) begin
      pos = len - 1 - i;
      case (w.op)
        OP_HEX: dig = 4'((mag >> (4 * pos)) & 32'hF);
        OP_BIN: dig = 4'((mag >> pos) & 32'h1);
        default: begin
          scale = 64'd1;
          for (int k = 0; k < pos; k++) scale = scale * 64'd10;
          dig = 4'((64'(mag) / scale) % 64'd10);
        end
      endcase
      g.line = w.text_line;
      g.column = col + 5'(i);
      g.code = (dig < 4'd10) ? CHAR_ZERO + 7'(dig) : CHAR_UPPER + 7'(dig - 4'd10);
      g.last = (i + 1 == len);
      expected_chars.push_back(g);
    end
  endfunction

  function automatic number_word_t make_number(input logic [1:0] op,
                                               input logic [31:0] value,
                                               input int count, input int line,
                                               input int column);
    number_word_t w;
    w.op = op;
    w.value = value;
    w.digit_count = 5'(count);
    w.text_line = 3'(line);
    w.start_column = 5'(column);
    return w;
  endfunction

  // send one number word; valid stays high afterwards for back-to-back words
  task automatic send_number(input number_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      num_bus.valid <= 1'b0;
      @(posedge clk);
    end
    num_bus.valid        <= 1'b1;
    num_bus.op           <= w.op;
    num_bus.value        <= w.value;
    num_bus.digit_count  <= w.digit_count;
    num_bus.text_line    <= w.text_line;
    num_bus.start_column <= w.start_column;
    do @(posedge clk); while (num_bus.ready !== 1'b1);
    predict_display_chars(w);
    numbers_sent++;
  endtask

  // drop valid and let every expected character come out
  task automatic drain_block();
    num_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // character checker and receiver stalls
  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    if (rst === 1'b0 && glyph_bus.valid === 1'b1 && glyph_bus.ready === 1'b1) begin
      got = {glyph_bus.out_line, glyph_bus.out_column, glyph_bus.char_code,
             glyph_bus.last};
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_error($sformatf("unexpected char: line %0d col %0d code %h last %b",
                               got.line, got.column, got.code, got.last));
      end else begin
        want = expected_chars.pop_front();
        if (got !== want)
          report_error($sformatf({"char mismatch: exp line %0d col %0d code %h last %b,",
                                  " got line %0d col %0d code %h last %b"},
                                 want.line, want.column, want.code, want.last,
                                 got.line, got.column, got.code, got.last));
      end
    end
    glyph_bus.ready <= (rst === 1'b0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // field extremes in every mode
  task automatic test_value_extremes();
    send_number(make_number(OP_UDEC, 32'd0,         10, 1, 1));
    send_number(make_number(OP_UDEC, 32'hFFFF_FFFF, 10, 2, 1));
    send_number(make_number(OP_SDEC, 32'h8000_0000, 10, 3, 1));  // most negative
    send_number(make_number(OP_SDEC, 32'h7FFF_FFFF, 10, 4, 1));
    send_number(make_number(OP_SDEC, 32'hFFFF_FFFF, 3,  1, 5));  // minus one
    send_number(make_number(OP_SDEC, 32'd0,         1,  2, 5));
    send_number(make_number(OP_HEX,  32'hDEAD_BEEF, 8,  3, 3));
    send_number(make_number(OP_HEX,  32'hFEDC_BA98, 8,  4, 9));
    send_number(make_number(OP_BIN,  32'h0000_A5C3, 16, 1, 1));
    send_number(make_number(OP_BIN,  32'hFFFF_0000, 16, 2, 1));  // upper bits unseen
  endtask

  // zero count, clamping and leading zeros
  task automatic test_digit_counts();
    send_number(make_number(OP_UDEC, 32'd123456,     0,  1, 1));  // no characters
    send_number(make_number(OP_HEX,  32'hABCD,       0,  1, 1));
    send_number(make_number(OP_BIN,  32'h5,          0,  1, 1));
    send_number(make_number(OP_SDEC, 32'hFFFF_FFFB,  0,  2, 7));  // sign alone
    send_number(make_number(OP_UDEC, 32'd987654321,  31, 3, 2));
    send_number(make_number(OP_HEX,  32'h1234_5678,  9,  4, 2));
    send_number(make_number(OP_BIN,  32'h0001_8001,  17, 1, 1));
    send_number(make_number(OP_SDEC, 32'd1,          16, 2, 1));
    send_number(make_number(OP_UDEC, 32'd42,         5,  3, 11));
  endtask

  // line pass-through and column wrap
  task automatic test_text_position();
    send_number(make_number(OP_UDEC, 32'd7,          2,  0, 0));
    send_number(make_number(OP_HEX,  32'h0F1E_2D3C,  8,  7, 31));
    send_number(make_number(OP_SDEC, 32'hC000_0001,  10, 5, 30));
    send_number(make_number(OP_BIN,  32'h0000_3C3C,  16, 6, 16));
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    number_word_t w;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      w.op = 2'($urandom_range(3));
      case ($urandom_range(4))
        0: w.value = $urandom_range(999);
        1: w.value = 32'h8000_0000 + $urandom_range(255) - 128;
        2: w.value = 32'hFFFF_FFFF - $urandom_range(1000);
        default: w.value = $urandom;
      endcase
      case ($urandom_range(9))
        0: w.digit_count = 5'd0;
        1: w.digit_count = 5'($urandom_range(31, 17));
        default: w.digit_count = 5'($urandom_range(16, 1));
      endcase
      w.text_line = 3'($urandom_range(7));
      w.start_column = 5'($urandom_range(31));
      send_number(w);
    end
    drain_block();
  endtask

  initial begin
    rst <= 1'b1;
    num_bus.valid <= 1'b0;
    num_bus.op <= OP_UDEC;
    num_bus.value <= '0;
    num_bus.digit_count <= '0;
    num_bus.text_line <= '0;
    num_bus.start_column <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_value_extremes();
    test_digit_counts();
    test_text_position();
    drain_block();
    test_random_traffic(34, 0, 0);
    test_random_traffic(34, 71, 0);
    test_random_traffic(34, 0, 71);
    test_random_traffic(34, 17, 17);

    if (expected_chars.size() != 0)
      report_error($sformatf("%0d characters never arrived", expected_chars.size()));
    $display("Ran %0d numbers in all four modes, %0d characters checked, %0d errors",
             numbers_sent, chars_checked, error_count);
    $display("Phases: back-to-back, sender gaps, receiver stalls, and both mixed");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
